// File: src/msgt_pkg.sv
// msgt_pkg: shared types, constants and codes for the multi-stop gradient table
// no dependencies
`default_nettype none
package msgt_pkg;
   localparam int MAX_STOPS_DEF = 16;
   localparam int POS_W = 17;
   localparam int COLOR_W = 32;
   localparam int LEN_W = 17;
   localparam int IDX_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam logic [POS_W-1:0] ONE_FIX = 17'h10000;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // capture request fields
      logic ins_step;    // shift one stop up (from top) or write new stop
      logic clear;
      logic seg_start;   // reset segment walk
      logic seg_step;    // evaluate one stop boundary
      logic div_start;
      logic div_step;
      logic res_load;    // latch result
   } cmd_type;

   typedef struct packed {
      logic ins_done;
      logic full;
      logic seg_found;
      logic seg_done;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

// File: src/multi_stop_gradient_table_unit.sv
// multi_stop_gradient_table_unit: top level, csr registers, controller and datapath
// depends on msgt_pkg, msgt_ctrl, msgt_datapath
//
// Request channel (req_): kind 0 inserts a stop, 1 clears the stop table,
// 2 looks up one entry of the gradient table. One transaction at a time.
// Response channel (rsp_): one transaction per request with RGBA and status.
// An insert shifts the stops above its position up one slot at a time; a dropped
// insert, a clear and an unused kind 3 go straight to the response; a lookup walks
// the stops in order and, when the entry is interpolated, runs the 24-step
// bit-serial divider, with one lane for each of the four channels, while an index
// at or past the end returns end_color without the divider.
// The csr_ port writes start_color (0), end_color (1), table_length (2); the user
// must write them only while idle, as the block itself does not enforce this.
// Reset empties the stop table and loads the register reset values.
// The response register holds while rsp_stall is high; no new request is
// taken until the response is delivered.
`default_nettype none
module multi_stop_gradient_table_unit #(
   parameter int MAX_STOPS = msgt_pkg::MAX_STOPS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [1:0] req_kind,
   input  wire logic [msgt_pkg::POS_W-1:0] req_stop_position,
   input  wire logic [msgt_pkg::COLOR_W-1:0] req_stop_color,
   input  wire logic [msgt_pkg::IDX_W-1:0] req_entry_index,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_alpha,
   output logic rsp_status,
   input  wire logic csr_write,
   input  wire logic [msgt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [msgt_pkg::COLOR_W-1:0] csr_data
);
   import msgt_pkg::*;
   logic [COLOR_W-1:0] start_ff, end_ff, rgba;
   logic [LEN_W-1:0] len_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff <= '1;
         len_ff <= LEN_W'(256);
      end else if (csr_write) begin
         case (csr_index)
            CSR_START: start_ff <= csr_data;
            CSR_END: end_ff <= csr_data;
            CSR_LEN: len_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   msgt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   msgt_datapath #(.MAX_STOPS(MAX_STOPS)) u_dp (
      .clock, .reset, .cmd, .sts, .req_kind, .req_stop_position,
      .req_stop_color, .req_entry_index, .start_color(start_ff),
      .end_color(end_ff), .table_length(len_ff), .rsp_rgba(rgba),
      .rsp_stat(rsp_status)
   );

   assign rsp_out_red = rgba[7:0];
   assign rsp_out_green = rgba[15:8];
   assign rsp_out_blue = rgba[23:16];
   assign rsp_out_alpha = rgba[31:24];
endmodule
`default_nettype wire

// File: src/msgt_datapath.sv
// msgt_datapath: stop table registers, segment walker, serial divider
// depends on msgt_pkg
`default_nettype none
module msgt_datapath #(
   parameter int MAX_STOPS = msgt_pkg::MAX_STOPS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire msgt_pkg::cmd_type cmd,
   output msgt_pkg::sts_type sts,
   input  wire logic [1:0] req_kind,
   input  wire logic [msgt_pkg::POS_W-1:0] req_stop_position,
   input  wire logic [msgt_pkg::COLOR_W-1:0] req_stop_color,
   input  wire logic [msgt_pkg::IDX_W-1:0] req_entry_index,
   input  wire logic [msgt_pkg::COLOR_W-1:0] start_color,
   input  wire logic [msgt_pkg::COLOR_W-1:0] end_color,
   input  wire logic [msgt_pkg::LEN_W-1:0] table_length,
   output logic [msgt_pkg::COLOR_W-1:0] rsp_rgba,
   output logic rsp_stat
);
   import msgt_pkg::*;
   localparam int CNT_W = $clog2(MAX_STOPS + 1);
   localparam int SI_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;

   logic [POS_W-1:0]   pos_ff [MAX_STOPS];
   logic [COLOR_W-1:0] col_ff [MAX_STOPS];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [1:0]         kind_ff;
   logic [POS_W-1:0]   npos_ff;
   logic [COLOR_W-1:0] ncol_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   l_ff, w_ff, j_ff;
   logic [COLOR_W-1:0] cl_ff, ch_ff;
   logic [IDX_W-1:0]   last_ff;
   logic               past_ff;
   logic               drop_ff;
   logic [COLOR_W-1:0] rgba_ff;
   logic               stat_ff;
   // divider: 4 lanes, numerator 24 bits, restoring
   logic [23:0]        num_ff [4];
   logic [IDX_W:0]     rem_ff [4];
   logic [4:0]         dcnt_ff;

   logic [SI_W-1:0] ptr_idx, prev_idx;
   logic [LEN_W-1:0] len_c;
   logic [IDX_W-1:0] last_c, h_c;
   logic [COLOR_W-1:0] ch_c;
   logic [POS_W+IDX_W-1:0] prod;
   logic [POS_W-1:0] npos_c;
   logic at_end;

   assign ptr_idx = ptr_ff[SI_W-1:0];
   assign prev_idx = SI_W'(ptr_ff - CNT_W'(1));
   assign npos_c = (req_stop_position > ONE_FIX) ? ONE_FIX : req_stop_position;
   assign len_c = (table_length < LEN_W'(2)) ? LEN_W'(2) :
                  (table_length > LEN_W'(65536)) ? LEN_W'(65536) : table_length;
   assign last_c = IDX_W'(len_c - LEN_W'(1));
   assign at_end = (ptr_ff >= count_ff);
   assign prod = POS_W'(at_end ? '0 : pos_ff[ptr_idx]) * last_ff;
   // position <= 1.0 keeps the boundary within 16 bits
   assign h_c = at_end ? last_ff : prod[POS_W+IDX_W-2:16];
   assign ch_c = at_end ? end_color : col_ff[ptr_idx];

   assign sts.full = (count_ff >= CNT_W'(MAX_STOPS));
   // insertion sweep from top: stop when slot below is smaller than new position
   assign sts.ins_done = (ptr_ff == '0) || (pos_ff[prev_idx] < npos_ff);
   assign sts.seg_found = (idx_ff < h_c) && (h_c > l_ff);
   assign sts.seg_done = at_end;
   assign sts.div_done = (dcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear && kind_ff == KIND_CLEAR) begin
         count_ff <= '0;
      end else if (cmd.ins_step && sts.ins_done) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= 5'd24;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         npos_ff <= npos_c;
         ncol_ff <= req_stop_color;
         idx_ff <= req_entry_index;
         ptr_ff <= count_ff;
         last_ff <= last_c;
         past_ff <= ({1'b0, req_entry_index} >= {1'b0, last_c});
         drop_ff <= (req_kind == KIND_INSERT) && sts.full;
      end
      if (cmd.ins_step) begin
         if (sts.ins_done) begin
            pos_ff[ptr_idx] <= npos_ff;
            col_ff[ptr_idx] <= ncol_ff;
         end else begin
            pos_ff[ptr_idx] <= pos_ff[prev_idx];
            col_ff[ptr_idx] <= col_ff[prev_idx];
            ptr_ff <= ptr_ff - CNT_W'(1);
         end
      end
      if (cmd.seg_start) begin
         ptr_ff <= '0;
         l_ff <= '0;
         cl_ff <= start_color;
      end
      if (cmd.seg_step) begin
         ch_ff <= ch_c;
         if (sts.seg_found) begin
            w_ff <= h_c - l_ff;
            j_ff <= idx_ff - l_ff;
         end else begin
            if (h_c > l_ff) l_ff <= h_c;
            cl_ff <= ch_c;
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
      end
      if (cmd.div_start) begin
         for (int k = 0; k < 4; k++) begin
            num_ff[k] <= 24'(w_ff - j_ff) * 24'(cl_ff[8*k +: 8]) +
                         24'(j_ff) * 24'(ch_ff[8*k +: 8]);
            rem_ff[k] <= '0;
         end
      end
      if (cmd.div_step) begin
         for (int k = 0; k < 4; k++) begin
            logic [IDX_W+1:0] t;
            t = {rem_ff[k], num_ff[k][23]};
            if (t >= {2'b00, w_ff}) begin
               rem_ff[k] <= (IDX_W+1)'(t - {2'b00, w_ff});
               num_ff[k] <= {num_ff[k][22:0], 1'b1};
            end else begin
               rem_ff[k] <= t[IDX_W:0];
               num_ff[k] <= {num_ff[k][22:0], 1'b0};
            end
         end
      end
      if (cmd.res_load) begin
         stat_ff <= drop_ff;
         if (kind_ff != KIND_LOOKUP) rgba_ff <= '0;
         else if (past_ff || at_end && !sts.seg_found) rgba_ff <= end_color;
         else rgba_ff <= {num_ff[3][7:0], num_ff[2][7:0], num_ff[1][7:0], num_ff[0][7:0]};
      end
   end

   assign rsp_rgba = rgba_ff;
   assign rsp_stat = stat_ff;
endmodule
`default_nettype wire

// File: src/msgt_ctrl.sv
// msgt_ctrl: sequencing state machine for insert, clear and lookup
// depends on msgt_pkg
`default_nettype none
module msgt_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [1:0] req_kind,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output msgt_pkg::cmd_type cmd,
   input  wire msgt_pkg::sts_type sts
);
   import msgt_pkg::*;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INS = 3'd1;
   localparam logic [2:0] ST_SEG = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_RES = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;
   localparam logic [2:0] ST_PRE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff;
   logic accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = accept;
            if (accept) state_in = ST_PRE;
         end
         ST_PRE: begin
            if (kind_ff == KIND_INSERT && !sts.full) state_in = ST_INS;
            else if (kind_ff == KIND_LOOKUP) begin
               cmd.seg_start = 1'b1;
               state_in = ST_SEG;
            end else begin
               cmd.clear = 1'b1;
               state_in = ST_RES;
            end
         end
         ST_INS: begin
            cmd.ins_step = 1'b1;
            if (sts.ins_done) state_in = ST_RES;
         end
         ST_SEG: begin
            cmd.seg_step = 1'b1;
            if (sts.seg_found) state_in = ST_DIV;
            else if (sts.seg_done) state_in = ST_RES;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_RES;
         end
         ST_RES: begin
            if (kind_ff == KIND_LOOKUP && !sts.div_done) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.res_load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      if (accept) kind_ff <= req_kind;
   end
endmodule
`default_nettype wire

// File: src/msgt_checker.sv
// msgt_checker: port-level assertions, bound to the top level
// depends on multi_stop_gradient_table_unit ports
`default_nettype none
module msgt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_status,
   input wire logic [7:0] rsp_out_red
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_red))
      else $error("response changed under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_out_red == 8'd0)
      else $error("dropped insert shows color");
endmodule
bind multi_stop_gradient_table_unit msgt_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_out_red
);
`default_nettype wire
